// ----- sv/qrs_pkg.sv -----
`timescale 1ns / 1ps

package qrs_pkg;

  function automatic int max3(input int x, input int y, input int z);
    int m;
    m = (x > y) ? x : y;
    return (m > z) ? m : z;
  endfunction

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int DISC_W = 2 * DATA_WIDTH + 1;
  localparam int SD_W   = 2 * DATA_WIDTH + 3;
  localparam int ROOT_W = (DISC_W + 1) / 2;
  localparam int NUM_W  = max3(DATA_WIDTH + FRAC_BITS, 2 * DATA_WIDTH, ROOT_W + FRAC_BITS) + 1;
  localparam int NB_W   = NUM_W + 1;
  localparam int DEN_W  = DATA_WIDTH + 1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NEG_DISC = 2'd1,
    STAT_A_ZERO   = 2'd2,
    STAT_SAT      = 2'd3
  } status_t;

endpackage

// ----- sv/qrs_sqrt.sv -----
`timescale 1ns / 1ps

module qrs_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qrs_pkg::DISC_W-1:0]   rad,
  output logic [qrs_pkg::ROOT_W-1:0]   root
);
  import qrs_pkg::*;

  localparam int DP_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [DP_W-1:0]   dsh [ROOT_W];
  logic [REM_W-1:0]  rem [ROOT_W];
  logic [ROOT_W-1:0] res [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [DP_W-1:0]   d_in;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] res_in;

    if (k == 0) begin : g_first
      assign d_in   = DP_W'(rad);
      assign rem_in = '0;
      assign res_in = '0;
    end else begin : g_next
      assign d_in   = dsh[k-1];
      assign rem_in = rem[k-1];
      assign res_in = res[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], d_in[DP_W-1 -: 2]};
    assign trial  = {1'b0, res_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        dsh[k] <= d_in << 2;
        if (rem_sh >= trial) begin
          rem[k] <= rem_sh - trial;
          res[k] <= {res_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem[k] <= rem_sh;
          res[k] <= {res_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = res[ROOT_W-1];

endmodule

// ----- sv/qrs_div.sv -----
`timescale 1ns / 1ps

module qrs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qrs_pkg::NUM_W-1:0]  num,
  input  logic [qrs_pkg::DEN_W-1:0]  den,
  output logic [qrs_pkg::NUM_W-1:0]  quo
);
  import qrs_pkg::*;

  localparam int RW = DEN_W + 1;

  logic [NUM_W-1:0] nq  [NUM_W];
  logic [DEN_W-1:0] rem [NUM_W];
  logic [DEN_W-1:0] dv  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_st
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] dv_in;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign dv_in  = den;
    end else begin : g_next
      assign nq_in  = nq[k-1];
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
    end

    assign rem_sh = {rem_in, nq_in[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, dv_in};
    assign ge     = rem_sh >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k]  <= {nq_in[NUM_W-2:0], ge};
        rem[k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = nq[NUM_W-1];

endmodule

// ----- sv/quadratic_root_solver.sv -----
`timescale 1ns / 1ps

// Real roots of a*x^2 + b*x + c in signed Q16.16, standard form (a, b, c) or vertex
// form (a, h, k). Fully pipelined: one equation enters per cycle unless the output
// stalls, passing through the bit-per-stage square root (33 stages) and the
// bit-per-stage dividers (65 stages). A stall on the output holds the whole pipeline.
// Status: 0 ok, 1 negative discriminant, 2 zero a, 3 a root clamped to the Q16.16
// range; roots are zero for status 1 and 2.
module quadratic_root_solver (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_a,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_p,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_q,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] root_plus,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] root_minus,
  output logic [1:0]                            status
);
  import qrs_pkg::*;

  localparam int LAT = ROOT_W + NUM_W + 4;

  typedef struct packed {
    logic signed [NB_W-1:0] negb;
    logic [DEN_W-1:0]       den;
    logic                   a_neg;
    status_t                stat;
  } side1_t;

  typedef struct packed {
    logic    p_neg;
    logic    m_neg;
    status_t stat;
  } side2_t;

  function automatic logic [DATA_WIDTH:0] clamp(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0]      lim;
    logic [NUM_W-1:0]      mag;
    logic [DATA_WIDTH-1:0] v;
    lim = neg ? (NUM_W'(1) << (DATA_WIDTH - 1)) : ((NUM_W'(1) << (DATA_WIDTH - 1)) - NUM_W'(1));
    mag = (q > lim) ? lim : q;
    v   = neg ? -mag[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    return {(q > lim), v};
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  logic signed [PROD_W-1:0]     s1_aq;
  logic signed [PROD_W-1:0]     s1_pp;
  logic signed [PROD_W-1:0]     s1_ap;
  logic signed [DATA_WIDTH-1:0] s1_a;
  logic signed [DATA_WIDTH-1:0] s1_p;
  logic                         s1_func;

  logic signed [SD_W-1:0]         t4;
  logic signed [SD_W-1:0]         disc_s;
  logic signed [NB_W-1:0]         negb_s;
  logic signed [DATA_WIDTH+1:0]   two_a;
  logic [DATA_WIDTH+1:0]          two_a_mag;
  side1_t                         side1_next;

  logic [DISC_W-1:0] s2_disc;
  side1_t            s2_side;
  side1_t            sd1 [ROOT_W];
  logic [ROOT_W-1:0] root;

  logic signed [NB_W-1:0] sf;
  logic signed [NB_W-1:0] np;
  logic signed [NB_W-1:0] nm;
  logic [NB_W-1:0]        np_mag;
  logic [NB_W-1:0]        nm_mag;

  logic [NUM_W-1:0] s3_num_p;
  logic [NUM_W-1:0] s3_num_m;
  logic [DEN_W-1:0] s3_den;
  side2_t           s3_side;
  side2_t           sd2 [NUM_W];

  logic [NUM_W-1:0]    quo_p;
  logic [NUM_W-1:0]    quo_m;
  logic [DATA_WIDTH:0] cl_p;
  logic [DATA_WIDTH:0] cl_m;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_aq   <= coef_a * coef_q;
      s1_pp   <= coef_p * coef_p;
      s1_ap   <= coef_a * coef_p;
      s1_a    <= coef_a;
      s1_p    <= coef_p;
      s1_func <= func;
    end
  end

  always_comb begin
    t4        = -(SD_W'(s1_aq) <<< 2);
    disc_s    = s1_func ? t4 : SD_W'(s1_pp) + t4;
    negb_s    = s1_func ? (NB_W'(s1_ap) <<< 1) : -(NB_W'(s1_p) <<< FRAC_BITS);
    two_a     = (DATA_WIDTH + 2)'(s1_a) <<< 1;
    two_a_mag = two_a[DATA_WIDTH+1] ? -two_a : two_a;
    side1_next.negb  = negb_s;
    side1_next.den   = two_a_mag[DEN_W-1:0];
    side1_next.a_neg = s1_a[DATA_WIDTH-1];
    priority if (s1_a == '0) begin
      side1_next.stat = STAT_A_ZERO;
    end else if (disc_s[SD_W-1]) begin
      side1_next.stat = STAT_NEG_DISC;
    end else begin
      side1_next.stat = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_disc <= disc_s[SD_W-1] ? '0 : disc_s[DISC_W-1:0];
      s2_side <= side1_next;
    end
  end

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s2_disc),
    .root (root)
  );

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sd1
    always_ff @(posedge clk) begin
      if (en) begin
        sd1[k] <= (k == 0) ? s2_side : sd1[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_comb begin
    sf     = signed'(NB_W'(root)) <<< FRAC_BITS;
    np     = sd1[ROOT_W-1].negb + sf;
    nm     = sd1[ROOT_W-1].negb - sf;
    np_mag = np[NB_W-1] ? -np : np;
    nm_mag = nm[NB_W-1] ? -nm : nm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_p      <= np_mag[NUM_W-1:0];
      s3_num_m      <= nm_mag[NUM_W-1:0];
      s3_den        <= sd1[ROOT_W-1].den;
      s3_side.p_neg <= np[NB_W-1] ^ sd1[ROOT_W-1].a_neg;
      s3_side.m_neg <= nm[NB_W-1] ^ sd1[ROOT_W-1].a_neg;
      s3_side.stat  <= sd1[ROOT_W-1].stat;
    end
  end

  qrs_div u_div_p (
    .clk (clk),
    .en  (en),
    .num (s3_num_p),
    .den (s3_den),
    .quo (quo_p)
  );

  qrs_div u_div_m (
    .clk (clk),
    .en  (en),
    .num (s3_num_m),
    .den (s3_den),
    .quo (quo_m)
  );

  for (genvar k = 0; k < NUM_W; k++) begin : g_sd2
    always_ff @(posedge clk) begin
      if (en) begin
        sd2[k] <= (k == 0) ? s3_side : sd2[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign cl_p = clamp(quo_p, sd2[NUM_W-1].p_neg);
  assign cl_m = clamp(quo_m, sd2[NUM_W-1].m_neg);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd2[NUM_W-1].stat != STAT_OK) begin
        root_plus  <= '0;
        root_minus <= '0;
        status     <= sd2[NUM_W-1].stat;
      end else begin
        root_plus  <= cl_p[DATA_WIDTH-1:0];
        root_minus <= cl_m[DATA_WIDTH-1:0];
        status     <= (cl_p[DATA_WIDTH] || cl_m[DATA_WIDTH]) ? STAT_SAT : STAT_OK;
      end
    end
  end

endmodule

// ----- verif/qrs_checker.sv -----
`timescale 1ns / 1ps

module qrs_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  func,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_a,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_p,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_q,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] root_plus,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] root_minus,
  input  logic [1:0]                            status,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    roots_seen,
  output int                                    sat_seen,
  output int                                    neg_seen,
  output int                                    zero_seen
);
  import qrs_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] rp;
    logic signed [DATA_WIDTH-1:0] rm;
    status_t                      st;
  } roots_t;

  roots_t expected_roots[$];

  function automatic logic [127:0] isqrt(input logic [127:0] d);
    logic [127:0] s;
    logic [127:0] t;
    s = '0;
    for (int i = 40; i >= 0; i--) begin
      t = s | (128'd1 << i);
      if (t * t <= d) s = t;
    end
    return s;
  endfunction

  function automatic logic clamp_root(input logic signed [127:0] v,
                                      output logic signed [DATA_WIDTH-1:0] r);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
    lo = -(128'sd1 <<< (DATA_WIDTH - 1));
    if (v > hi) begin
      r = hi[DATA_WIDTH-1:0];
      return 1'b1;
    end
    if (v < lo) begin
      r = lo[DATA_WIDTH-1:0];
      return 1'b1;
    end
    r = v[DATA_WIDTH-1:0];
    return 1'b0;
  endfunction

  function automatic roots_t solve_quadratic(input logic f,
                                             input logic signed [DATA_WIDTH-1:0] a,
                                             input logic signed [DATA_WIDTH-1:0] p,
                                             input logic signed [DATA_WIDTH-1:0] q);
    roots_t r;
    logic signed [127:0] aa, pp, qq, disc, negb, sf, den;
    logic sat_p, sat_m;
    aa = a;
    pp = p;
    qq = q;
    r.rp = '0;
    r.rm = '0;
    if (a == 0) begin
      r.st = STAT_A_ZERO;
      return r;
    end
    if (f == 1'b0) begin
      disc = pp * pp - 4 * aa * qq;
      negb = -(pp <<< FRAC_BITS);
    end else begin
      disc = -4 * aa * qq;
      negb = 2 * aa * pp;
    end
    if (disc < 0) begin
      r.st = STAT_NEG_DISC;
      return r;
    end
    sf = $signed(isqrt(disc)) <<< FRAC_BITS;
    den = 2 * aa;
    sat_p = clamp_root((negb + sf) / den, r.rp);
    sat_m = clamp_root((negb - sf) / den, r.rm);
    r.st = (sat_p || sat_m) ? STAT_SAT : STAT_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    roots_t e;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
      roots_seen <= 0;
      sat_seen   <= 0;
      neg_seen   <= 0;
      zero_seen  <= 0;
    end else begin
      if (in_valid && in_ready) expected_roots.push_back(solve_quadratic(func, coef_a, coef_p, coef_q));
      if (out_valid && out_ready) begin
        roots_seen <= roots_seen + 1;
        if (expected_roots.size() == 0) begin
          $error("result with no pending transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_roots.pop_front();
          case (e.st)
            STAT_SAT:      sat_seen  <= sat_seen + 1;
            STAT_NEG_DISC: neg_seen  <= neg_seen + 1;
            STAT_A_ZERO:   zero_seen <= zero_seen + 1;
            default: ;
          endcase
          if (root_plus !== e.rp || root_minus !== e.rm || status !== e.st) begin
            if (root_plus !== e.rp)
              $error("root_plus expected %0d actual %0d", e.rp, root_plus);
            if (root_minus !== e.rm)
              $error("root_minus expected %0d actual %0d", e.rm, root_minus);
            if (status !== e.st)
              $error("status expected %0d actual %0d", e.st, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_roots.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import qrs_pkg::*;

  localparam int LIMIT_CYCLES = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic signed [DATA_WIDTH-1:0] coef_a = '0;
  logic signed [DATA_WIDTH-1:0] coef_p = '0;
  logic signed [DATA_WIDTH-1:0] coef_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0] root_plus;
  logic signed [DATA_WIDTH-1:0] root_minus;
  logic [1:0] status;
  int fail_count, pending, roots_seen, sat_seen, neg_seen, zero_seen;
  int cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  quadratic_root_solver u_dut (.*);

  qrs_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: stall pattern changes at random times, one long hold-off
  initial begin
    int mode;
    int held;
    held = 0;
    mode = 0;
    @(negedge clk);
    while (1) begin
      if (roots_seen > 250 && held == 0) begin
        held = 1;
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      if (($urandom % 64) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = ($urandom % 5) == 0;
        default: out_ready = ($urandom % 8) != 0;
      endcase
      @(negedge clk);
    end
  end

  task automatic send_quadratic(input logic f, input logic signed [31:0] a,
                                input logic signed [31:0] p, input logic signed [31:0] q);
    @(negedge clk);
    in_valid = 1'b1;
    func     = f;
    coef_a   = a;
    coef_p   = p;
    coef_q   = q;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coef();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return v;
      2, 3: return v >>> $urandom_range(4, 28);
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  initial begin
    logic signed [63:0] a, r1, r2;
    logic signed [31:0] ap, ak;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_quadratic(1'b0, 32'sd0, 32'sd65536, 32'sd65536);
    send_quadratic(1'b1, 32'sd0, 32'sh7fffffff, 32'sh80000000);
    send_quadratic(1'b0, 32'sd65536, 32'sd0, 32'sd65536);
    send_quadratic(1'b1, 32'sd65536, 32'sd0, 32'sd65536);
    send_quadratic(1'b0, 32'sd65536, 32'sd0, -32'sd262144);
    send_quadratic(1'b0, 32'sd65536, -32'sd196608, 32'sd131072);
    send_quadratic(1'b1, 32'sd65536, 32'sd131072, -32'sd65536);
    send_quadratic(1'b1, -32'sd65536, -32'sd131072, 32'sd65536);
    send_quadratic(1'b0, 32'sd1, 32'sh7fffffff, 32'sd0);
    send_quadratic(1'b0, 32'sd1, 32'sh80000000, 32'sh80000000);
    send_quadratic(1'b0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_quadratic(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_quadratic(1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_quadratic(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_quadratic(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_quadratic(1'b0, -32'sd1, 32'sd0, 32'sd0);
    send_quadratic(1'b1, 32'sd1, 32'sd0, 32'sd0);
    send_quadratic(1'b0, 32'sd65536, 32'sd0, 32'sd0);
    send_quadratic(1'b1, 32'sd3, 32'sh7fffffff, -32'sd5);
    send_quadratic(1'b0, 32'shffffffff, 32'shffffffff, 32'shffffffff);

    for (int i = 0; i < 800; i++) begin
      if (i == 400) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0 || out_valid) @(negedge clk);
      end
      if (($urandom % 16) == 0) idle_sender($urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0: begin
          a  = $signed($urandom_range(1, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
          r1 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          r2 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          send_quadratic(1'b0, a[31:0], 32'((-(a * (r1 + r2))) >>> 16),
                         32'((a * r1 * r2) >>> 32));
        end
        1: begin
          ap = rand_coef();
          ak = $signed($urandom) >>> $urandom_range(0, 20);
          if ((ap < 0) == (ak < 0)) ak = -ak;
          send_quadratic(1'b1, ap, rand_coef(), ak);
        end
        default: send_quadratic(1'($urandom_range(0, 1)), rand_coef(), rand_coef(),
                                rand_coef());
      endcase
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("sent %0d equations, checked %0d results", sent, roots_seen);
    $display("saturated %0d, negative discriminant %0d, zero a %0d",
             sat_seen, neg_seen, zero_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- quadratic_root_solver.f -----
sv/qrs_pkg.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
verif/qrs_checker.sv
verif/tb.sv
